// ===== design/adaptive_arith_encoder_core_defines.svh =====
// Assertion macros used by the encoder core.
`ifndef ADAPTIVE_ARITH_ENCODER_CORE_DEFINES_SVH
`define ADAPTIVE_ARITH_ENCODER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define AAE_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define AAE_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/aae_pkg.sv =====
`default_nettype none
package aae_pkg;

    localparam int ALPHABET_SIZE  = 256;
    localparam int SYM_W          = 8;
    localparam int CNT_W          = 25;
    localparam int PRECISION_BITS = 32;
    localparam int LOW_W          = PRECISION_BITS + 1;
    localparam int PROD_W         = LOW_W + CNT_W;
    localparam int PEND_W         = 8;
    localparam int STEP_W         = 6;
    localparam int MAX_RESULTS    = 40;
    localparam int BUF_AW         = 6;

    localparam logic [CNT_W-1:0]  TOTAL_LIMIT = CNT_W'(16777216);
    localparam logic [CNT_W-1:0]  TOTAL_RESET = CNT_W'(ALPHABET_SIZE);
    localparam logic [PEND_W-1:0] MAX_PENDING = PEND_W'(224);

    localparam logic [LOW_W-1:0] WHOLE_RANGE = LOW_W'(64'd1 << PRECISION_BITS);
    localparam logic [LOW_W-1:0] HALF_RANGE  = LOW_W'(64'd1 << (PRECISION_BITS - 1));
    localparam logic [LOW_W-1:0] QUART_RANGE = LOW_W'(64'd1 << (PRECISION_BITS - 2));
    localparam logic [LOW_W-1:0] THREE_QUART = HALF_RANGE + QUART_RANGE;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_FINISH = 1'b1
    } aae_op_t;

    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] symbol;
    } aae_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_end;
        logic       pending_overflow;
    } aae_out_t;

endpackage
`default_nettype wire

// ===== design/aae_muldiv.sv =====
`default_nettype none
// Computes round-half-up of span * num / total: a shift-add multiply, one bit of
// num per cycle, then a restoring division, one quotient bit per cycle.
module aae_muldiv (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [aae_pkg::LOW_W-1:0] span,
    input  wire logic [aae_pkg::CNT_W-1:0] num,
    input  wire logic [aae_pkg::CNT_W-1:0] total,
    output logic                           done,
    output logic [aae_pkg::LOW_W-1:0]      result
);
    import aae_pkg::*;

    typedef enum logic [3:0] {
        MD_IDLE = 4'b0001,
        MD_MUL  = 4'b0010,
        MD_DIV  = 4'b0100,
        MD_RND  = 4'b1000
    } md_state_t;

    md_state_t          st_reg, st_next;
    logic [6:0]         it_reg, it_next;
    logic               done_reg, done_next;
    logic [PROD_W-1:0]  acc_reg;
    logic [CNT_W-1:0]   num_reg;
    logic [LOW_W-1:0]   dist_reg;
    logic [CNT_W-1:0]   tot_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [LOW_W-1:0]   result_reg;
    logic [CNT_W:0]     trial;
    logic               ge;

    // One restoring division step.
    assign trial = {rem_reg, acc_reg[PROD_W-1]};
    assign ge    = (trial >= {1'b0, tot_reg});

    // Sequencer.
    always_comb
    begin
        st_next   = st_reg;
        it_next   = it_reg;
        done_next = 1'b0;
        case (st_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    st_next = MD_MUL;
                    it_next = 7'(CNT_W - 1);
                end
            end
            MD_MUL:
            begin
                if (it_reg == 7'd0)
                begin
                    st_next = MD_DIV;
                    it_next = 7'(PROD_W - 1);
                end
                else
                begin
                    it_next = it_reg - 7'd1;
                end
            end
            MD_DIV:
            begin
                if (it_reg == 7'd0)
                begin
                    st_next = MD_RND;
                end
                else
                begin
                    it_next = it_reg - 7'd1;
                end
            end
            MD_RND:
            begin
                st_next   = MD_IDLE;
                done_next = 1'b1;
            end
            default:
            begin
                st_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= MD_IDLE;
            it_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            it_reg   <= it_next;
            done_reg <= done_next;
        end
    end

    // Datapath: product, then quotient in the same shift register.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    acc_reg  <= '0;
                    num_reg  <= num;
                    dist_reg <= span;
                    tot_reg  <= total;
                    rem_reg  <= '0;
                end
            end
            MD_MUL:
            begin
                acc_reg <= {acc_reg[PROD_W-2:0], 1'b0}
                         + (num_reg[CNT_W-1] ? PROD_W'(dist_reg) : PROD_W'(0));
                num_reg <= {num_reg[CNT_W-2:0], 1'b0};
            end
            MD_DIV:
            begin
                rem_reg <= ge ? CNT_W'(trial - {1'b0, tot_reg}) : CNT_W'(trial);
                acc_reg <= {acc_reg[PROD_W-2:0], ge};
            end
            MD_RND:
            begin
                result_reg <= acc_reg[LOW_W-1:0]
                            + LOW_W'({rem_reg, 1'b0} >= {1'b0, tot_reg});
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== design/adaptive_arith_encoder_core.sv =====
`default_nettype none
// Order-0 adaptive arithmetic encoder over bytes with a 32-bit interval. Each input
// word is an encode (symbol) or a finish; it yields zero or more code bytes, first bit
// in the MSB, and up to 40 bytes per word are kept. One word is processed at a time.
// An encode walks the count memory for entries 0..symbol (one read per cycle), runs
// two passes through the shared serial multiply/divide unit, renormalizes, writing
// each code bit, and then delivers its bytes from the result buffer. A finish writes
// the terminating and padding bits, then delivers its bytes. Counts are held in a
// 256-entry memory with per-entry valid flops, so reset and finish clear the model
// at once with no clearing pass.
module adaptive_arith_encoder_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire aae_pkg::aae_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output aae_pkg::aae_out_t      out_data
);
    import aae_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_WALK  = 10'b00_0000_0010,
        S_MDHI  = 10'b00_0000_0100,
        S_MDLO  = 10'b00_0000_1000,
        S_RN    = 10'b00_0001_0000,
        S_EMIT  = 10'b00_0010_0000,
        S_PAD   = 10'b00_0100_0000,
        S_UPD   = 10'b00_1000_0000,
        S_DRAIN = 10'b01_0000_0000,
        S_DLOAD = 10'b10_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [LOW_W-1:0]         low_reg, low_next;
    logic [LOW_W-1:0]         high_reg, high_next;
    logic [LOW_W-1:0]         tmp_reg, tmp_next;
    logic [PEND_W-1:0]        pend_reg, pend_next;
    logic [7:0]               acc_reg, acc_next;
    logic [2:0]               pos_reg, pos_next;
    logic [CNT_W-1:0]         total_reg, total_next;
    logic [ALPHABET_SIZE-1:0] valid_reg, valid_next;
    logic [SYM_W-1:0]         idx_reg, idx_next;
    logic                     iss_done_reg, iss_done_next;
    logic                     rv_reg, rv_next;
    logic                     rlast_reg, rlast_next;
    logic [CNT_W-1:0]         cum_reg, cum_next;
    logic [SYM_W-1:0]         sym_reg, sym_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     ebit_reg, ebit_next;
    logic                     first_reg, first_next;
    logic                     fin_reg, fin_next;
    logic                     ovf_reg, ovf_next;
    logic [BUF_AW-1:0]        wcnt_reg, wcnt_next;
    logic [BUF_AW-1:0]        rptr_reg, rptr_next;
    logic                     out_valid_reg, out_valid_next;
    aae_out_t                 out_data_reg;

    // Count memory and result buffer.
    logic [CNT_W-1:0] cmem [ALPHABET_SIZE];
    logic [CNT_W-1:0] cq_reg;
    logic             vq_reg;
    logic [7:0]       obuf [MAX_RESULTS];
    logic [7:0]       bq_reg;

    logic             cm_rd_en, cm_wr_en;
    logic [CNT_W-1:0] cm_wr_data;
    logic             buf_wr_en, buf_rd_en;
    logic [7:0]       buf_wr_data;
    logic             out_load;
    logic             drain_last;
    logic [CNT_W-1:0] cnt_word;

    // Put-bit path into the byte accumulator.
    logic             pb_en, pb_bit;

    logic             md_start;
    logic [CNT_W-1:0] md_num;
    logic             md_done;
    logic [LOW_W-1:0] md_result;

    aae_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .span   (high_reg - low_reg),
        .num    (md_num),
        .total  (total_reg),
        .done   (md_done),
        .result (md_result)
    );

    assign cnt_word   = vq_reg ? cq_reg : CNT_W'(1);
    assign drain_last = (rptr_reg == (wcnt_reg - BUF_AW'(1)));
    assign out_load   = (state_reg == S_DLOAD) && (!out_valid_reg || out_ready);

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        tmp_next       = tmp_reg;
        pend_next      = pend_reg;
        total_next     = total_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        iss_done_next  = iss_done_reg;
        rv_next        = 1'b0;
        rlast_next     = rlast_reg;
        cum_next       = cum_reg;
        sym_next       = sym_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        ebit_next      = ebit_reg;
        first_next     = first_reg;
        fin_next       = fin_reg;
        ovf_next       = ovf_reg;
        rptr_next      = rptr_reg;
        cm_rd_en       = 1'b0;
        cm_wr_en       = 1'b0;
        cm_wr_data     = cnt_reg + CNT_W'(1);
        buf_rd_en      = 1'b0;
        pb_en          = 1'b0;
        pb_bit         = 1'b0;
        md_start       = 1'b0;
        md_num         = cum_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rptr_next = '0;
                    ovf_next  = 1'b0;
                    fin_next  = (in_data.op == OP_FINISH);
                    sym_next  = in_data.symbol;
                    if (in_data.op == OP_FINISH)
                    begin
                        // Terminating pending increment, then the final bit.
                        if (pend_reg < MAX_PENDING)
                        begin
                            pend_next = pend_reg + PEND_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        ebit_next  = (low_reg > QUART_RANGE);
                        first_next = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next      = '0;
                        iss_done_next = 1'b0;
                        cum_next      = '0;
                        state_next    = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // Issue reads for entries 0..symbol, accumulate as data returns.
                if (!iss_done_reg)
                begin
                    cm_rd_en   = 1'b1;
                    rv_next    = 1'b1;
                    rlast_next = (idx_reg == sym_reg);
                    if (idx_reg == sym_reg)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + SYM_W'(1);
                    end
                end
                if (rv_reg)
                begin
                    if (rlast_reg)
                    begin
                        cnt_next   = cnt_word;
                        md_start   = 1'b1;
                        md_num     = cum_reg + cnt_word;
                        state_next = S_MDHI;
                    end
                    else
                    begin
                        cum_next = cum_reg + cnt_word;
                    end
                end
            end
            S_MDHI:
            begin
                if (md_done)
                begin
                    tmp_next   = low_reg + md_result;
                    md_start   = 1'b1;
                    md_num     = cum_reg;
                    state_next = S_MDLO;
                end
            end
            S_MDLO:
            begin
                if (md_done)
                begin
                    low_next   = low_reg + md_result;
                    high_next  = tmp_reg;
                    step_next  = '0;
                    state_next = S_RN;
                end
            end
            S_RN:
            begin
                // One rescaling step per cycle while no bit is being written, at most PRECISION_BITS per symbol.
                if (step_reg == STEP_W'(PRECISION_BITS))
                begin
                    state_next = S_UPD;
                end
                else if (high_reg < HALF_RANGE)
                begin
                    low_next   = {low_reg[LOW_W-2:0], 1'b0};
                    high_next  = {high_reg[LOW_W-2:0], 1'b0};
                    ebit_next  = 1'b0;
                    first_next = 1'b1;
                    step_next  = step_reg + STEP_W'(1);
                    state_next = S_EMIT;
                end
                else if (low_reg > HALF_RANGE)
                begin
                    low_next   = (low_reg - HALF_RANGE) << 1;
                    high_next  = (high_reg - HALF_RANGE) << 1;
                    ebit_next  = 1'b1;
                    first_next = 1'b1;
                    step_next  = step_reg + STEP_W'(1);
                    state_next = S_EMIT;
                end
                else if ((low_reg > QUART_RANGE) && (high_reg < THREE_QUART))
                begin
                    low_next  = (low_reg - QUART_RANGE) << 1;
                    high_next = (high_reg - QUART_RANGE) << 1;
                    step_next = step_reg + STEP_W'(1);
                    if (pend_reg < MAX_PENDING)
                    begin
                        pend_next = pend_reg + PEND_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_EMIT:
            begin
                // The decided bit, then one opposite bit per pending count.
                pb_en  = 1'b1;
                pb_bit = first_reg ? ebit_reg : !ebit_reg;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    if (pend_reg == '0)
                    begin
                        state_next = fin_reg ? S_PAD : S_RN;
                    end
                end
                else
                begin
                    pend_next = pend_reg - PEND_W'(1);
                    if (pend_reg == PEND_W'(1))
                    begin
                        state_next = fin_reg ? S_PAD : S_RN;
                    end
                end
            end
            S_PAD:
            begin
                if (pos_reg == 3'd7)
                begin
                    // Stream closed: the whole model returns to its reset state.
                    low_next   = '0;
                    high_next  = WHOLE_RANGE;
                    pend_next  = '0;
                    total_next = TOTAL_RESET;
                    valid_next = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    pb_en  = 1'b1;
                    pb_bit = 1'b0;
                end
            end
            S_UPD:
            begin
                if (total_reg < TOTAL_LIMIT)
                begin
                    cm_wr_en   = 1'b1;
                    valid_next[sym_reg] = 1'b1;
                    total_next = total_reg + CNT_W'(1);
                end
                state_next = (wcnt_reg == '0) ? S_IDLE : S_DRAIN;
            end
            S_DRAIN:
            begin
                buf_rd_en  = 1'b1;
                state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                if (out_load)
                begin
                    rptr_next  = rptr_reg + BUF_AW'(1);
                    state_next = drain_last ? S_IDLE : S_DRAIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Byte packing, MSB first; bytes past the buffer size are dropped.
    always_comb
    begin
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        wcnt_next   = wcnt_reg;
        buf_wr_en   = 1'b0;
        buf_wr_data = acc_reg | (8'(pb_bit) << pos_reg);
        if ((state_reg == S_IDLE) && in_valid)
        begin
            wcnt_next = '0;
        end
        else if (pb_en)
        begin
            if (pos_reg == 3'd0)
            begin
                acc_next = '0;
                pos_next = 3'd7;
                if (wcnt_reg < BUF_AW'(MAX_RESULTS))
                begin
                    buf_wr_en = 1'b1;
                    wcnt_next = wcnt_reg + BUF_AW'(1);
                end
            end
            else
            begin
                acc_next = buf_wr_data;
                pos_next = pos_reg - 3'd1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            low_reg       <= '0;
            high_reg      <= WHOLE_RANGE;
            tmp_reg       <= '0;
            pend_reg      <= '0;
            acc_reg       <= '0;
            pos_reg       <= 3'd7;
            total_reg     <= TOTAL_RESET;
            valid_reg     <= '0;
            idx_reg       <= '0;
            iss_done_reg  <= 1'b0;
            rv_reg        <= 1'b0;
            rlast_reg     <= 1'b0;
            cum_reg       <= '0;
            sym_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            ebit_reg      <= 1'b0;
            first_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            wcnt_reg      <= '0;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            tmp_reg       <= tmp_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            valid_reg     <= valid_next;
            idx_reg       <= idx_next;
            iss_done_reg  <= iss_done_next;
            rv_reg        <= rv_next;
            rlast_reg     <= rlast_next;
            cum_reg       <= cum_next;
            sym_reg       <= sym_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            ebit_reg      <= ebit_next;
            first_reg     <= first_next;
            fin_reg       <= fin_next;
            ovf_reg       <= ovf_next;
            wcnt_reg      <= wcnt_next;
            rptr_reg      <= rptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Count memory: one read and one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (cm_wr_en)
        begin
            cmem[sym_reg] <= cm_wr_data;
        end
        if (cm_rd_en)
        begin
            cq_reg <= cmem[idx_reg];
            vq_reg <= valid_reg[idx_reg];
        end
    end

    // Result buffer for one input word.
    always_ff @(posedge clk)
    begin
        if (buf_wr_en)
        begin
            obuf[wcnt_reg] <= buf_wr_data;
        end
        if (buf_rd_en)
        begin
            bq_reg <= obuf[rptr_reg];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.out_byte         <= bq_reg;
            out_data_reg.last_of_run      <= drain_last;
            out_data_reg.stream_end       <= drain_last && fin_reg;
            out_data_reg.pending_overflow <= ovf_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "adaptive_arith_encoder_core_defines.svh"

    `AAE_ALWAYS(a_buf_bound, wcnt_reg <= BUF_AW'(MAX_RESULTS), "result count past buffer")
    `AAE_ALWAYS(a_pend_bound, pend_reg <= MAX_PENDING, "pending count past saturation")
    `AAE_IMPLIES(a_interval_order, state_reg == S_RN, low_reg <= high_reg, "interval inverted")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
    import aae_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    aae_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    aae_out_t out_data;

    adaptive_arith_encoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Encoder model state, kept at the block's widths.
    logic [CNT_W-1:0]  freq [ALPHABET_SIZE];
    logic [CNT_W-1:0]  freq_sum;
    logic [LOW_W-1:0]  code_low;
    logic [LOW_W-1:0]  code_high;
    logic [PEND_W-1:0] pend_cnt;
    logic [7:0]        acc_byte;
    logic [2:0]        acc_pos;
    logic              word_ovf;

    aae_in_t  word_queue [$];
    aae_out_t code_queue [$];
    aae_out_t word_bytes [$];

    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_send;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void clear_model();
        for (int i = 0; i < ALPHABET_SIZE; i++)
            freq[i] = CNT_W'(1);
        freq_sum  = TOTAL_RESET;
        code_low  = '0;
        code_high = WHOLE_RANGE;
        pend_cnt  = '0;
        acc_byte  = '0;
        acc_pos   = 3'd7;
    endfunction

    function automatic void emit_bit(logic b);
        aae_out_t r;
        acc_byte[acc_pos] = acc_byte[acc_pos] | b;
        if (acc_pos == 3'd0)
        begin
            r = '0;
            r.out_byte = acc_byte;
            if (word_bytes.size() < MAX_RESULTS)
                word_bytes.push_back(r);
            acc_byte = '0;
            acc_pos  = 3'd7;
        end
        else
            acc_pos = acc_pos - 3'd1;
    endfunction

    function automatic void emit_with_pending(logic b);
        emit_bit(b);
        while (pend_cnt != 0)
        begin
            emit_bit(~b);
            pend_cnt = pend_cnt - 1'b1;
        end
    endfunction

    function automatic void add_pending();
        if (pend_cnt < MAX_PENDING)
            pend_cnt = pend_cnt + 1'b1;
        else
            word_ovf = 1'b1;
    endfunction

    // Round-half-up of span * num / freq_sum.
    function automatic logic [63:0] scale_frac(logic [63:0] span, logic [63:0] num);
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] r;
        prod = span * num;
        q = prod / 64'(freq_sum);
        r = prod % 64'(freq_sum);
        if (2 * r >= 64'(freq_sum))
            q = q + 1;
        return q;
    endfunction

    // Works out the code bytes one word produces and queues them.
    function automatic void encode_word(aae_in_t w);
        logic [63:0] cum;
        logic [63:0] span;
        logic [63:0] lo;
        logic [63:0] hi;
        word_bytes.delete();
        word_ovf = 1'b0;
        if (w.op == OP_ENCODE)
        begin
            cum = 0;
            for (int i = 0; i < int'(w.symbol); i++)
                cum += freq[i];
            span = code_high - code_low;
            hi = code_low + scale_frac(span, cum + freq[w.symbol]);
            lo = code_low + scale_frac(span, cum);
            for (int n = 0; n < PRECISION_BITS; n++)
            begin
                if (hi < HALF_RANGE)
                    emit_with_pending(1'b0);
                else if (lo > HALF_RANGE)
                begin
                    lo -= HALF_RANGE;
                    hi -= HALF_RANGE;
                    emit_with_pending(1'b1);
                end
                else if (lo > QUART_RANGE && hi < THREE_QUART)
                begin
                    lo -= QUART_RANGE;
                    hi -= QUART_RANGE;
                    add_pending();
                end
                else
                    break;
                lo = lo << 1;
                hi = hi << 1;
            end
            code_low  = LOW_W'(lo);
            code_high = LOW_W'(hi);
            if (freq_sum < TOTAL_LIMIT)
            begin
                freq[w.symbol] = freq[w.symbol] + 1'b1;
                freq_sum = freq_sum + 1'b1;
            end
        end
        else
        begin
            add_pending();
            emit_with_pending(code_low <= QUART_RANGE ? 1'b0 : 1'b1);
            while (acc_pos != 3'd7)
                emit_bit(1'b0);
            if (word_bytes.size() > 0)
                word_bytes[word_bytes.size() - 1].stream_end = 1'b1;
            clear_model();
        end
        foreach (word_bytes[k])
            word_bytes[k].pending_overflow = word_ovf;
        if (word_bytes.size() > 0)
            word_bytes[word_bytes.size() - 1].last_of_run = 1'b1;
        foreach (word_bytes[k])
            code_queue.push_back(word_bytes[k]);
    endfunction

    function automatic aae_in_t make_word(logic op, int sym);
        aae_in_t w;
        w.op = op;
        w.symbol = SYM_W'(sym);
        return w;
    endfunction

    // Driver: presents queued words, holding valid and data until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                encode_word(in_data);
            if (!in_valid || in_ready)
            begin
                if (word_queue.size() > 0 && !hold_send
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= word_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each delivered code byte and sets the receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (code_queue.size() == 0)
                begin
                    $error("unexpected code byte %02h", out_data.out_byte);
                    errors++;
                end
                else
                begin
                    aae_out_t e;
                    e = code_queue.pop_front();
                    if (e.out_byte !== out_data.out_byte)
                    begin
                        $error("out_byte expected %02h got %02h", e.out_byte, out_data.out_byte);
                        errors++;
                    end
                    if (e.last_of_run !== out_data.last_of_run)
                    begin
                        $error("last_of_run expected %0b got %0b",
                               e.last_of_run, out_data.last_of_run);
                        errors++;
                    end
                    if (e.stream_end !== out_data.stream_end)
                    begin
                        $error("stream_end expected %0b got %0b",
                               e.stream_end, out_data.stream_end);
                        errors++;
                    end
                    if (e.pending_overflow !== out_data.pending_overflow)
                    begin
                        $error("pending_overflow expected %0b got %0b",
                               e.pending_overflow, out_data.pending_overflow);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drained();
        while (!(word_queue.size() == 0 && !in_valid && code_queue.size() == 0))
            @(posedge clk);
    endtask

    task automatic run_random(int count);
        int sym;
        for (int i = 0; i < count; i++)
        begin
            // Mostly skewed symbols so the model adapts, some uniform ones.
            if ($urandom_range(3) == 0)
                sym = $urandom_range(255);
            else
                sym = $urandom_range(3) * 60 + $urandom_range(2);
            if ($urandom_range(29) == 0)
                word_queue.push_back(make_word(OP_FINISH, $urandom_range(255)));
            else
                word_queue.push_back(make_word(OP_ENCODE, sym));
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_send = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 54;
        clear_model();
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: symbol extremes, finish on a fresh stream, repeated runs.
        word_queue.push_back(make_word(OP_FINISH, 0));
        word_queue.push_back(make_word(OP_ENCODE, 0));
        word_queue.push_back(make_word(OP_ENCODE, 255));
        word_queue.push_back(make_word(OP_ENCODE, 128));
        word_queue.push_back(make_word(OP_ENCODE, 127));
        word_queue.push_back(make_word(OP_ENCODE, 8'h55));
        word_queue.push_back(make_word(OP_ENCODE, 8'hAA));
        word_queue.push_back(make_word(OP_FINISH, 255));
        for (int i = 0; i < 8; i++)
            word_queue.push_back(make_word(OP_ENCODE, 0));
        word_queue.push_back(make_word(OP_FINISH, 0));
        // Symbols near the middle of the range drive long pending-bit chains.
        for (int i = 0; i < 6; i++)
            word_queue.push_back(make_word(OP_ENCODE, 127 + (i % 2)));
        word_queue.push_back(make_word(OP_FINISH, 0));
        wait_drained();

        // Random words with both sides stalling, then wait until everything has come out.
        run_random(80);
        wait_drained();

        send_idle_pct = 54;
        recv_idle_pct = 27;
        run_random(80);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(70);
        word_queue.push_back(make_word(OP_FINISH, 0));
        wait_drained();
        repeat (200) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/aae_pkg.sv
design/aae_muldiv.sv
design/adaptive_arith_encoder_core.sv
tb/sv/testbench.sv
